### design/ulcp_pkg.sv
`timescale 1ns / 1ps

package ulcp_pkg;

    localparam int LINE_CAPACITY = 128;
    localparam int LEN_W = $clog2(LINE_CAPACITY);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    localparam int KW_COUNT = 6;
    localparam int KW_BAUD = 0;
    localparam int KW_CSUM = 1;
    localparam int KW_END = 2;
    localparam int KW_UPDATE = 3;
    localparam int KW_LEDON = 4;
    localparam int KW_LEDOFF = 5;
    localparam int PREFIX_LEN = 9;

    localparam logic [2:0] RESP_CONFIG_OK = 3'd0;
    localparam logic [2:0] RESP_CSUM_FAIL = 3'd1;
    localparam logic [2:0] RESP_SEND_CFG  = 3'd2;
    localparam logic [2:0] RESP_LED_ON    = 3'd3;
    localparam logic [2:0] RESP_LED_OFF   = 3'd4;
    localparam logic [2:0] RESP_INVALID   = 3'd5;

    // Summary of one finished, non-empty line handed from the front to the back.
    typedef struct packed {
        logic        is_end;
        logic        is_update;
        logic        is_led_on;
        logic        is_led_off;
        logic        baud_line;
        logic        csum_line;
        logic        hex_valid;
        logic [7:0]  hex_value;
        logic [7:0]  line_xor;
        logic [31:0] baud_value;
    } line_summary_t;

endpackage

### design/ulcp_front.sv
`timescale 1ns / 1ps

module ulcp_front
    import ulcp_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          byte_valid,
    input  logic [7:0]    rx_byte,
    output logic          push,
    output line_summary_t push_data
);

    localparam logic [8*13-1:0] KW_TEXT [KW_COUNT] = '{
        "BAUDRATE=", "CHECKSUM=", {"END_", "CONFIG"}, {"UPDATE_", "CONFIG"}, "LED_ON", "LED_OFF"
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd9, 4'd9, 4'd10, 4'd13, 4'd6, 4'd7};

    // Parse phases for the baud field and for the checksum field.
    localparam logic [2:0] PH_BLANK    = 3'd0;
    localparam logic [2:0] PH_DIG_POS  = 3'd1;
    localparam logic [2:0] PH_DIG_NEG  = 3'd2;
    localparam logic [2:0] PH_DONE_POS = 3'd3;
    localparam logic [2:0] PH_DONE_NEG = 3'd4;
    localparam logic [2:0] PH_HEX_ONE  = 3'd1;
    localparam logic [2:0] PH_HEX_TWO  = 3'd2;
    localparam logic [2:0] PH_HEX_NONE = 3'd3;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [31:0] SAT_MAG = 32'h8000_0000;
    localparam logic [31:0] MAX_POS = 32'h7FFF_FFFF;
    localparam logic [LEN_W-1:0] KEEP_LIMIT = LEN_W'(LINE_CAPACITY - 1);

    function automatic logic [7:0] kw_char(input int k, input logic [3:0] pos);
        logic [3:0] idx;
        idx = KW_LEN[k] - 4'd1 - pos;
        return KW_TEXT[k][idx*8 +: 8];
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C;
    endfunction

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= "0" && c <= "9") begin
            v = c - 8'h30;
            return {1'b1, v[3:0]};
        end
        if (c >= "a" && c <= "f") begin
            v = c - 8'h57;
            return {1'b1, v[3:0]};
        end
        if (c >= "A" && c <= "F") begin
            v = c - 8'h37;
            return {1'b1, v[3:0]};
        end
        return 5'b0;
    endfunction

    logic [LEN_W-1:0]    len_reg, len_next;
    logic [7:0]          xor_reg, xor_next;
    logic [KW_COUNT-1:0] flags_reg, flags_next;
    logic [31:0]         dec_reg, dec_next;
    logic [2:0]          phase_reg, phase_next;
    logic [7:0]          hex_reg, hex_next;

    logic                is_digit;
    logic [3:0]          dec_digit;
    logic [35:0]         dec_prod;
    logic [4:0]          hexd;
    logic                neg;

    always_comb begin
        len_next = len_reg;
        xor_next = xor_reg;
        flags_next = flags_reg;
        dec_next = dec_reg;
        phase_next = phase_reg;
        hex_next = hex_reg;
        push = 1'b0;
        is_digit = rx_byte >= "0" && rx_byte <= "9";
        dec_digit = 4'(rx_byte - 8'h30);
        dec_prod = ({4'b0, dec_reg} << 3) + ({4'b0, dec_reg} << 1) + {32'b0, dec_digit};
        hexd = hex_digit(rx_byte);

        if (byte_valid && rx_byte != CH_CR) begin
            if (rx_byte == CH_LF) begin
                push = len_reg != '0;
                len_next = '0;
                xor_next = '0;
                flags_next = '1;
                dec_next = '0;
                phase_next = PH_BLANK;
                hex_next = '0;
            end else if (len_reg < KEEP_LIMIT) begin
                for (int k = 0; k < KW_COUNT; k++) begin
                    if (flags_reg[k]) begin
                        if (len_reg < LEN_W'(KW_LEN[k])) begin
                            if (rx_byte != kw_char(k, len_reg[3:0])) begin
                                flags_next[k] = 1'b0;
                            end
                        end else if (k >= KW_END) begin
                            flags_next[k] = 1'b0;
                        end
                    end
                end
                if (len_reg >= LEN_W'(PREFIX_LEN)) begin
                    if (flags_next[KW_BAUD]) begin
                        if (phase_reg == PH_BLANK) begin
                            if (is_blank(rx_byte)) begin
                                phase_next = PH_BLANK;
                            end else if (rx_byte == "+") begin
                                phase_next = PH_DIG_POS;
                            end else if (rx_byte == "-") begin
                                phase_next = PH_DIG_NEG;
                            end else if (is_digit) begin
                                dec_next = {28'b0, dec_digit};
                                phase_next = PH_DIG_POS;
                            end else begin
                                phase_next = PH_DONE_POS;
                            end
                        end else if (phase_reg == PH_DIG_POS || phase_reg == PH_DIG_NEG) begin
                            if (is_digit) begin
                                dec_next = (dec_prod > {4'b0, SAT_MAG}) ? SAT_MAG : dec_prod[31:0];
                            end else begin
                                phase_next = phase_reg + 3'd2;
                            end
                        end
                    end else if (flags_next[KW_CSUM]) begin
                        if (phase_reg == PH_BLANK) begin
                            if (!is_blank(rx_byte)) begin
                                if (hexd[4]) begin
                                    hex_next = {4'b0, hexd[3:0]};
                                    phase_next = PH_HEX_ONE;
                                end else begin
                                    phase_next = PH_HEX_NONE;
                                end
                            end
                        end else if (phase_reg == PH_HEX_ONE) begin
                            if (hexd[4]) begin
                                hex_next = {hex_reg[3:0], hexd[3:0]};
                            end
                            phase_next = PH_HEX_TWO;
                        end
                    end
                end
                xor_next = xor_reg ^ rx_byte;
                len_next = len_reg + 1'b1;
            end
        end
    end

    // Line summary is built from the state before the line feed.
    always_comb begin
        neg = phase_reg == PH_DIG_NEG || phase_reg == PH_DONE_NEG;
        push_data.is_end = flags_reg[KW_END] && len_reg == LEN_W'(KW_LEN[KW_END]);
        push_data.is_update = flags_reg[KW_UPDATE] && len_reg == LEN_W'(KW_LEN[KW_UPDATE]);
        push_data.is_led_on = flags_reg[KW_LEDON] && len_reg == LEN_W'(KW_LEN[KW_LEDON]);
        push_data.is_led_off = flags_reg[KW_LEDOFF] && len_reg == LEN_W'(KW_LEN[KW_LEDOFF]);
        push_data.baud_line = flags_reg[KW_BAUD] && len_reg >= LEN_W'(PREFIX_LEN);
        push_data.csum_line = flags_reg[KW_CSUM] && len_reg >= LEN_W'(PREFIX_LEN);
        push_data.hex_valid = phase_reg == PH_HEX_ONE || phase_reg == PH_HEX_TWO;
        push_data.hex_value = hex_reg;
        push_data.line_xor = xor_reg;
        if (neg) begin
            push_data.baud_value = 32'd0 - dec_reg;
        end else begin
            push_data.baud_value = dec_reg[31] ? MAX_POS : dec_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
            xor_reg <= '0;
            flags_reg <= '1;
            dec_reg <= '0;
            phase_reg <= PH_BLANK;
            hex_reg <= '0;
        end else begin
            len_reg <= len_next;
            xor_reg <= xor_next;
            flags_reg <= flags_next;
            dec_reg <= dec_next;
            phase_reg <= phase_next;
            hex_reg <= hex_next;
        end
    end

endmodule

### design/ulcp_queue.sv
`timescale 1ns / 1ps

module ulcp_queue
    import ulcp_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  line_summary_t push_data,
    output logic          full,
    output logic          not_empty,
    input  logic          pop,
    output line_summary_t pop_data
);

    line_summary_t       mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;

    assign full = count_reg == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### design/ulcp_back.sv
`timescale 1ns / 1ps

module ulcp_back
    import ulcp_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          line_valid,
    input  line_summary_t line_data,
    output logic          line_pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [39:0]   m_tdata
);

    logic        cfg_mode_reg, cfg_mode_next;
    logic        led_reg, led_next;
    logic [7:0]  run_csum_reg, run_csum_next;
    logic [7:0]  rcv_csum_reg, rcv_csum_next;
    logic [31:0] pend_baud_reg, pend_baud_next;
    logic        baud_pend_reg, baud_pend_next;

    logic        out_valid_reg, out_valid_next;
    logic [2:0]  resp_reg, resp_next;
    logic        out_led_reg, out_led_next;
    logic        apply_reg, apply_next;
    logic [31:0] rate_reg, rate_next;

    assign line_pop = line_valid && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata = {3'b000, rate_reg, apply_reg, out_led_reg, resp_reg};

    always_comb begin
        cfg_mode_next = cfg_mode_reg;
        led_next = led_reg;
        run_csum_next = run_csum_reg;
        rcv_csum_next = rcv_csum_reg;
        pend_baud_next = pend_baud_reg;
        baud_pend_next = baud_pend_reg;
        out_valid_next = out_valid_reg && !m_tready;
        resp_next = resp_reg;
        out_led_next = out_led_reg;
        apply_next = apply_reg;
        rate_next = rate_reg;

        if (line_pop) begin
            if (cfg_mode_reg && !line_data.is_end) begin
                // Config body lines update the checksum and pending baud state and answer nothing.
                if (!line_data.csum_line) begin
                    run_csum_next = run_csum_reg ^ line_data.line_xor;
                end
                if (line_data.baud_line) begin
                    pend_baud_next = line_data.baud_value;
                    baud_pend_next = 1'b1;
                end else if (line_data.csum_line && line_data.hex_valid) begin
                    rcv_csum_next = line_data.hex_value;
                end
            end else begin
                out_valid_next = 1'b1;
                apply_next = 1'b0;
                rate_next = '0;
                if (cfg_mode_reg) begin
                    if (run_csum_reg == rcv_csum_reg) begin
                        resp_next = RESP_CONFIG_OK;
                        apply_next = baud_pend_reg;
                        rate_next = baud_pend_reg ? pend_baud_reg : '0;
                    end else begin
                        resp_next = RESP_CSUM_FAIL;
                    end
                    cfg_mode_next = 1'b0;
                end else if (line_data.is_update) begin
                    resp_next = RESP_SEND_CFG;
                    cfg_mode_next = 1'b1;
                end else if (line_data.is_led_on) begin
                    resp_next = RESP_LED_ON;
                    led_next = 1'b1;
                end else if (line_data.is_led_off) begin
                    resp_next = RESP_LED_OFF;
                    led_next = 1'b0;
                end else begin
                    resp_next = RESP_INVALID;
                end
                if (cfg_mode_reg || line_data.is_update) begin
                    run_csum_next = '0;
                    rcv_csum_next = '0;
                    pend_baud_next = '0;
                    baud_pend_next = 1'b0;
                end
                out_led_next = led_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_mode_reg <= 1'b0;
            led_reg <= 1'b0;
            run_csum_reg <= '0;
            rcv_csum_reg <= '0;
            pend_baud_reg <= '0;
            baud_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            cfg_mode_reg <= cfg_mode_next;
            led_reg <= led_next;
            run_csum_reg <= run_csum_next;
            rcv_csum_reg <= rcv_csum_next;
            pend_baud_reg <= pend_baud_next;
            baud_pend_reg <= baud_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        resp_reg <= resp_next;
        out_led_reg <= out_led_next;
        apply_reg <= apply_next;
        rate_reg <= rate_next;
    end

endmodule

### design/uart_line_command_parser_unit.sv
`timescale 1ns / 1ps
// Line command parser for received serial bytes.
// The s_ channel takes one received byte per transaction. Carriage returns are
// dropped, a line feed ends the line, and at most 127 characters of a line are kept.
// The m_ channel carries one response per answered line: every non-empty line in
// normal mode (invalid ones included) and the end-of-configuration line answer;
// config body lines and empty lines give no transaction.
// The front matches keywords and parses fields one byte per cycle while the queue
// has room; a finished line goes as a summary into a two-entry queue, and the back
// updates mode, LED and checksum state and loads the output register.
// Throughput: one byte per cycle while s_tready is high.
// A line's summary enters the queue when its line feed is accepted; the back pops it
// into the output register once that register is empty or being read.
// When the receiver stalls, the output register holds its response, the queue
// takes up to two more line summaries, and then s_tready drops until room frees up.
// Reset (aresetn low at a clock edge) returns to normal mode with the LED off,
// clears the partial line, the queue and the checksum state, and drops any response.

module uart_line_command_parser_unit
    import ulcp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [2:0] response, [3] led_level, [4] apply_baud,
                                   // [36:5] baud value, [39:37] zero
);

    logic          q_full;
    logic          q_not_empty;
    logic          q_push;
    logic          q_pop;
    line_summary_t q_push_data;
    line_summary_t q_pop_data;

    assign s_tready = !q_full;

    ulcp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_valid(s_tvalid && s_tready),
        .rx_byte   (s_tdata),
        .push      (q_push),
        .push_data (q_push_data)
    );

    ulcp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop       (q_pop),
        .pop_data  (q_pop_data)
    );

    ulcp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .line_valid(q_not_empty),
        .line_data (q_pop_data),
        .line_pop  (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
